// ===== sv/base64_line_wrapped_encoder_assert.svh =====
// Assertion macros for the Base64 line-wrapped encoder.
`ifndef BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define B64LWE_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define B64LWE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define B64LWE_ASSERT_NOW(lbl, cond, msg)
`define B64LWE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/b64lwe_pkg.sv =====
// Shared types, constants and the symbol function of the Base64 encoder.
package b64lwe_pkg;

	localparam logic [7:0] CHAR_CR  = 8'd13;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [5:0] GPL_RESET = 6'd19;

	typedef enum logic [1:0] {
		PH_BYTE0,
		PH_BYTE1,
		PH_BYTE2
	} phase_t;

	// characters caused by one input byte
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	typedef struct packed {
		phase_t     phase;
		logic [5:0] line_cnt;
	} front_stat_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_stat_t;

	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26)
			r = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			r = 8'h61 + {2'b00, v} - 8'd26;
		else if (v < 6'd62)
			r = 8'h30 + {2'b00, v} - 8'd52;
		else if (v == 6'd62)
			r = 8'h2B;
		else
			r = 8'h2F;
		return r;
	endfunction

endpackage

// ===== sv/b64lwe_front.sv =====
// Front end: takes bytes, tracks group and line state, builds character jobs.
module b64lwe_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [7:0]                data_byte,
	input  logic                      final_byte,
	input  logic [5:0]                groups_per_line,
	output b64lwe_pkg::job_t          job,
	output b64lwe_pkg::front_stat_t   stat
);
	import b64lwe_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic [3:0] lo_q, lo_nxt;
	logic [5:0] line_cnt_q, line_cnt_nxt;
	logic [5:0] cnt_inc;

	assign cnt_inc = line_cnt_q + 6'd1;

	always_comb begin
		job          = '0;
		job.fin      = final_byte;
		phase_nxt    = phase_q;
		lo_nxt       = lo_q;
		line_cnt_nxt = line_cnt_q;
		unique case (phase_q)
			PH_BYTE1: begin
				job.chars[0] = b64_sym({lo_q[1:0], data_byte[7:4]});
				if (final_byte) begin
					job.chars[1] = b64_sym({data_byte[3:0], 2'b00});
					job.chars[2] = CHAR_PAD;
					job.last_idx = 2'd2;
				end else begin
					job.last_idx = 2'd0;
					lo_nxt       = data_byte[3:0];
					phase_nxt    = PH_BYTE2;
				end
			end
			PH_BYTE2: begin
				job.chars[0] = b64_sym({lo_q, data_byte[7:6]});
				job.chars[1] = b64_sym(data_byte[5:0]);
				if (cnt_inc == groups_per_line) begin
					job.chars[2] = CHAR_CR;
					job.chars[3] = CHAR_LF;
					job.last_idx = 2'd3;
					line_cnt_nxt = '0;
				end else begin
					job.last_idx = 2'd1;
					line_cnt_nxt = cnt_inc;
				end
				phase_nxt = PH_BYTE0;
				lo_nxt    = '0;
			end
			default: begin
				// first byte of a group; an unused phase code lands here too
				job.chars[0] = b64_sym(data_byte[7:2]);
				if (final_byte) begin
					job.chars[1] = b64_sym({data_byte[1:0], 4'b0000});
					job.chars[2] = CHAR_PAD;
					job.chars[3] = CHAR_PAD;
					job.last_idx = 2'd3;
				end else begin
					job.last_idx = 2'd0;
					lo_nxt       = {2'b00, data_byte[1:0]};
					phase_nxt    = PH_BYTE1;
				end
			end
		endcase
		if (final_byte) begin
			phase_nxt    = PH_BYTE0;
			lo_nxt       = '0;
			line_cnt_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_BYTE0;
			lo_q       <= '0;
			line_cnt_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_nxt;
			lo_q       <= lo_nxt;
			line_cnt_q <= line_cnt_nxt;
		end
	end

	assign stat.phase    = phase_q;
	assign stat.line_cnt = line_cnt_q;

endmodule

// ===== sv/b64lwe_queue.sv =====
// Short job queue between the front end and the character emitter.
module b64lwe_queue #(
	parameter int DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  b64lwe_pkg::job_t          wr_data,
	input  logic                      rd_en,
	output b64lwe_pkg::job_t          rd_data,
	output b64lwe_pkg::queue_stat_t   stat
);
	import b64lwe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign stat.full      = (cnt_q == CNT_FULL);
	assign stat.not_empty = (cnt_q != '0);
	assign do_wr          = wr_en && !stat.full;
	assign do_rd          = rd_en && stat.not_empty;
	assign rd_data        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== sv/b64lwe_back.sv =====
// Back end: walks each job one character per cycle into the output register while it is empty or popped.
module b64lwe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64lwe_pkg::job_t  head,
	input  logic              head_valid,
	output logic              head_done,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_char,
	output logic              run_last,
	output logic              message_end
);
	import b64lwe_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic       load;
	logic       at_last;

	assign load      = !out_valid_q || pop;
	assign at_last   = (idx_q == head.last_idx);
	assign head_done = load && head_valid && at_last;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_char    <= head.chars[idx_q];
			run_last    <= at_last;
			message_end <= at_last && head.fin;
		end
	end

endmodule

// ===== sv/base64_line_wrapped_encoder.sv =====
// Base64 encoder with CR LF line wrapping: top level.
// A byte's characters pass through the job queue and then the output register before they can be popped.
// Throughput: one character per cycle from the output register while pop is held; a byte is
// taken every cycle while the job queue has room.
// Reset clears group phase, leftover bits, line count, queue and output valid;
// groups_per_line returns to 19.
`include "base64_line_wrapped_encoder_assert.svh"

module base64_line_wrapped_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       message_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data
);
	import b64lwe_pkg::*;

	logic [5:0]  gpl_q;
	logic        accept;
	job_t        new_job, head_job;
	front_stat_t front_st;
	queue_stat_t queue_st;
	logic        head_done;

	assign cfg_ready = 1'b1;
	assign full      = queue_st.full;
	assign accept    = push && !queue_st.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gpl_q <= GPL_RESET;
		else if (cfg_valid && cfg_ready)
			gpl_q <= cfg_data;
	end

	b64lwe_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (data_byte),
		.final_byte      (final_byte),
		.groups_per_line (gpl_q),
		.job             (new_job),
		.stat            (front_st)
	);

	b64lwe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (new_job),
		.rd_en   (head_done),
		.rd_data (head_job),
		.stat    (queue_st)
	);

	b64lwe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.head_valid  (queue_st.not_empty),
		.head_done   (head_done),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

	`B64LWE_ASSERT_NOW(a_end_is_run_last, !(!empty && message_end && !run_last),
		"message end without run end")
	`B64LWE_ASSERT_NOW(a_lf_ends_run, !(!empty && out_char == CHAR_LF && !run_last),
		"LF not last of its byte")
	`B64LWE_ASSERT_NEXT(a_final_clears, accept && final_byte,
		front_st.phase == PH_BYTE0 && front_st.line_cnt == 6'd0,
		"state not cleared after final byte")

endmodule
